### src/sorted_priority_queue_unit_macros.svh
// Assertion macros used by the checker file of the priority queue.
// No dependencies; each macro expects clk and rst in scope.
`ifndef SORTED_PRIORITY_QUEUE_UNIT_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define SPQU_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sorted priority queue check failed");

// next-cycle implication, disabled during reset
`define SPQU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sorted priority queue check failed");

`endif

### src/spqu_pkg.sv
// Shared types, codes and defaults of the sorted priority queue.
// No dependencies; used by the cell, the top level and the checker.
package spqu_pkg;

  localparam int DEPTH_DEFAULT = 16;
  localparam int PRIO_W        = 16;
  localparam int ID_W          = 8;
  localparam int KEY_W         = PRIO_W + ID_W;
  localparam int ERR_W         = 2;
  localparam int OCC_OUT_W     = 5;
  localparam int IN_DATA_W     = 24;
  localparam int OUT_DATA_W    = 64;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_POP    = 1'b1;

  localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
  localparam logic [ERR_W-1:0] ERR_EMPTY = 2'd1;
  localparam logic [ERR_W-1:0] ERR_FULL  = 2'd2;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_POP
  } op_t;

  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
  } slot_t;

  typedef struct packed {
    op_t              op;
    logic [KEY_W-1:0] key;
  } cmd_t;

endpackage

### src/spqu_cell.sv
// One slot of the sorted chain: holds an entry, shifts right on insert, left on pop.
// Depends on spqu_pkg.
module spqu_cell (
  input  logic          clk,
  input  logic          rst,
  input  spqu_pkg::cmd_t  cmd,
  input  spqu_pkg::slot_t prev_slot,
  input  logic          prev_gt,
  input  spqu_pkg::slot_t next_slot,
  output spqu_pkg::slot_t slot,
  output spqu_pkg::slot_t slot_next,
  output logic          gt
);
  import spqu_pkg::*;

  logic             valid;
  logic [KEY_W-1:0] key;

  assign slot.valid = valid;
  assign slot.key   = key;
  assign gt         = !valid || (key > cmd.key);

  always_comb begin
    slot_next = slot;
    case (cmd.op)
      OP_INSERT: begin
        if (gt) begin
          if (prev_gt) begin
            slot_next = prev_slot;
          end else begin
            slot_next.valid = 1'b1;
            slot_next.key   = cmd.key;
          end
        end
      end
      OP_POP:  slot_next = next_slot;
      default: slot_next = slot;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= slot_next.valid;
    end
  end

  always_ff @(posedge clk) begin
    key <= slot_next.key;
  end

endmodule

### src/sorted_priority_queue_unit.sv
// Sorted priority queue: a chain of DEPTH slot cells kept in ascending key order.
// Input channel s_* carries requests (s_tuser = action: 0 insert, 1 pop).
// Output channel m_* carries one result per request: popped entry, head after
//   the request, occupancy and an error code (pop when empty, insert when full).
// Each request is handled by a single cell update: all cells compare against the new key in
//   parallel and shift by one slot, so a request is accepted every cycle while
//   the result register is free or being drained.
// The result is registered: it appears on m_* in the cycle after the request is accepted.
// Throughput: one request per cycle while the output is not stalled.
// If the receiver stalls, the result holds in the output register and s_tready
//   drops until it is taken.
// Reset (rst, synchronous, active high) empties the queue and the result
//   register; stored keys are not cleared, only their valid bits.
// Depends on spqu_pkg and spqu_cell.
module sorted_priority_queue_unit #(
  parameter int DEPTH = spqu_pkg::DEPTH_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // [15:0] key_priority, [23:16] process_id
  input  logic [spqu_pkg::IN_DATA_W-1:0]  s_tdata,
  // [0] action
  input  logic                            s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // [1:0] error_code, [2] popped_valid, [18:3] popped_priority, [26:19] popped_id,
  // [27] head_valid, [43:28] head_priority, [51:44] head_id, [56:52] occupancy,
  // [63:57] zero
  output logic [spqu_pkg::OUT_DATA_W-1:0] m_tdata
);
  import spqu_pkg::*;

  localparam int OCC_W = $clog2(DEPTH + 1);

  slot_t            slot_cur [DEPTH];
  slot_t            slot_nxt [DEPTH];
  logic             gt       [DEPTH];
  cmd_t             cmd;
  logic             accept;
  logic             full;
  logic             empty;
  logic [KEY_W-1:0] new_key;
  logic [ERR_W-1:0] err;
  logic [OCC_W-1:0] occ;
  logic [OCC_W-1:0] occ_next;
  logic [31:0]      occ_wide;

  logic             out_valid;
  logic [OUT_DATA_W-1:0] out_data;
  logic [OUT_DATA_W-1:0] out_data_next;

  assign s_tready = !out_valid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign full     = slot_cur[DEPTH-1].valid;
  assign empty    = !slot_cur[0].valid;
  assign new_key  = {s_tdata[PRIO_W-1:0], s_tdata[PRIO_W +: ID_W]};

  always_comb begin
    cmd.op  = OP_HOLD;
    cmd.key = new_key;
    err     = ERR_OK;
    if (accept) begin
      if (s_tuser == ACT_INSERT) begin
        if (full) err = ERR_FULL;
        else      cmd.op = OP_INSERT;
      end else begin
        if (empty) err = ERR_EMPTY;
        else       cmd.op = OP_POP;
      end
    end
  end

  genvar i;
  generate
    for (i = 0; i < DEPTH; i++) begin : g_cell
      slot_t prev_s;
      slot_t next_s;
      logic  prev_g;
      if (i == 0) begin : g_first
        assign prev_s = '0;
        assign prev_g = 1'b0;
      end else begin : g_mid
        assign prev_s = slot_cur[i-1];
        assign prev_g = gt[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
        assign next_s = '0;
      end else begin : g_inner
        assign next_s = slot_cur[i+1];
      end
      spqu_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .cmd       (cmd),
        .prev_slot (prev_s),
        .prev_gt   (prev_g),
        .next_slot (next_s),
        .slot      (slot_cur[i]),
        .slot_next (slot_nxt[i]),
        .gt        (gt[i])
      );
    end
  endgenerate

  always_comb begin
    case (cmd.op)
      OP_INSERT: occ_next = occ + OCC_W'(1);
      OP_POP:    occ_next = occ - OCC_W'(1);
      default:   occ_next = occ;
    endcase
  end

  assign occ_wide = 32'(occ_next);

  always_comb begin
    out_data_next         = '0;
    out_data_next[1:0]    = err;
    if (cmd.op == OP_POP) begin
      out_data_next[2]     = 1'b1;
      out_data_next[18:3]  = slot_cur[0].key[KEY_W-1:ID_W];
      out_data_next[26:19] = slot_cur[0].key[ID_W-1:0];
    end
    if (slot_nxt[0].valid) begin
      out_data_next[27]    = 1'b1;
      out_data_next[43:28] = slot_nxt[0].key[KEY_W-1:ID_W];
      out_data_next[51:44] = slot_nxt[0].key[ID_W-1:0];
    end
    out_data_next[56:52]  = occ_wide[OCC_OUT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ       <= '0;
      out_valid <= 1'b0;
    end else begin
      occ <= occ_next;
      if (accept) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= out_data_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

endmodule

### src/spqu_checker.sv
// Port-level checks of the sorted priority queue, bound to the top level.
// Depends on spqu_pkg and sorted_priority_queue_unit_macros.svh.
`include "sorted_priority_queue_unit_macros.svh"

module spqu_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [spqu_pkg::OUT_DATA_W-1:0] m_tdata
);
  import spqu_pkg::*;

  logic [ERR_W-1:0]  err;
  logic              pv;
  logic [KEY_W-1:0]  popped_key;
  logic              hv;
  logic [KEY_W-1:0]  head_key;
  logic [4:0]        occ;

  assign err        = m_tdata[1:0];
  assign pv         = m_tdata[2];
  assign popped_key = {m_tdata[18:3], m_tdata[26:19]};
  assign hv         = m_tdata[27];
  assign head_key   = {m_tdata[43:28], m_tdata[51:44]};
  assign occ        = m_tdata[56:52];

  `SPQU_ASSERT_NEXT(a_hold_stall, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
  `SPQU_ASSERT_NOW(a_err_code, m_tvalid,
    err == ERR_OK || err == ERR_EMPTY || err == ERR_FULL)
  `SPQU_ASSERT_NOW(a_occ_head, m_tvalid && occ != 5'd0, hv)
  `SPQU_ASSERT_NOW(a_pop_order, m_tvalid && pv && hv, err == ERR_OK && popped_key <= head_key)

endmodule

bind sorted_priority_queue_unit spqu_checker u_spqu_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

### bench/tb.sv
// Self-checking bench for sorted_priority_queue_unit: a table of directed requests, then
// random insert/pop traffic with idle and stall on both stream sides.
// Depends on spqu_pkg and the RTL; keeps its own sorted-queue predictor.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import spqu_pkg::*;

  localparam int QDEPTH     = DEPTH_DEFAULT;
  localparam int RAND_ITEMS = 1300;
  localparam int IDLE_LIMIT = 1000;
  localparam int DIR_N      = 24;

  // packed to match m_tdata[56:0], highest field first
  typedef struct packed {
    logic [4:0]  occupancy;
    logic [7:0]  head_id;
    logic [15:0] head_priority;
    logic        head_valid;
    logic [7:0]  popped_id;
    logic [15:0] popped_priority;
    logic        popped_valid;
    logic [1:0]  error_code;
  } result_t;

  typedef struct packed {
    logic        action;
    logic [15:0] key_priority;
    logic [7:0]  process_id;
    logic        typed;
    result_t     want;
  } stim_row_t;

  // want: occupancy, head id/priority/valid, popped id/priority/valid, error_code
  localparam stim_row_t DIR_ROWS [DIR_N] = '{
    '{ACT_POP,    16'h0000, 8'h00, 1'b1,
      '{5'd0, 8'h00, 16'h0000, 1'b0, 8'h00, 16'h0000, 1'b0, ERR_EMPTY}},
    '{ACT_INSERT, 16'hFFFF, 8'hFF, 1'b1,
      '{5'd1, 8'hFF, 16'hFFFF, 1'b1, 8'h00, 16'h0000, 1'b0, ERR_OK}},
    '{ACT_INSERT, 16'h0000, 8'h00, 1'b1,
      '{5'd2, 8'h00, 16'h0000, 1'b1, 8'h00, 16'h0000, 1'b0, ERR_OK}},
    '{ACT_INSERT, 16'h8000, 8'h80, 1'b0, '0},
    '{ACT_INSERT, 16'h8000, 8'h80, 1'b0, '0},
    '{ACT_INSERT, 16'h8000, 8'h7F, 1'b0, '0},
    '{ACT_INSERT, 16'h8000, 8'h81, 1'b0, '0},
    '{ACT_INSERT, 16'h7FFF, 8'hFF, 1'b0, '0},
    '{ACT_INSERT, 16'h0001, 8'h00, 1'b0, '0},
    '{ACT_INSERT, 16'hFFFF, 8'h00, 1'b0, '0},
    '{ACT_INSERT, 16'hFFFF, 8'hFF, 1'b0, '0},
    '{ACT_INSERT, 16'h5555, 8'h55, 1'b0, '0},
    '{ACT_INSERT, 16'hAAAA, 8'hAA, 1'b0, '0},
    '{ACT_INSERT, 16'h0000, 8'hFF, 1'b0, '0},
    '{ACT_INSERT, 16'h1234, 8'h56, 1'b0, '0},
    '{ACT_INSERT, 16'h00FF, 8'h01, 1'b0, '0},
    '{ACT_INSERT, 16'h0000, 8'h00, 1'b1,
      '{5'd16, 8'h00, 16'h0000, 1'b1, 8'h00, 16'h0000, 1'b0, ERR_OK}},
    '{ACT_INSERT, 16'h4321, 8'h12, 1'b1,
      '{5'd16, 8'h00, 16'h0000, 1'b1, 8'h00, 16'h0000, 1'b0, ERR_FULL}},
    '{ACT_POP,    16'h0000, 8'h00, 1'b1,
      '{5'd15, 8'h00, 16'h0000, 1'b1, 8'h00, 16'h0000, 1'b1, ERR_OK}},
    '{ACT_POP,    16'hFFFF, 8'hFF, 1'b0, '0},
    '{ACT_POP,    16'h0000, 8'h00, 1'b0, '0},
    '{ACT_INSERT, 16'hFFFF, 8'hFF, 1'b0, '0},
    '{ACT_POP,    16'h0000, 8'h00, 1'b0, '0},
    '{ACT_POP,    16'h0000, 8'h00, 1'b0, '0}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic        s_tuser = ACT_INSERT;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;

  logic [23:0] held_keys [QDEPTH];
  int unsigned held_count = 0;
  result_t     pending_results [$];
  int unsigned mismatch_count = 0;
  int unsigned idle_cycles = 0;
  bit          no_idle = 1'b0;

  sorted_priority_queue_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic result_t apply_queue_op(logic action, logic [15:0] prio, logic [7:0] pid);
    result_t     r;
    logic [23:0] key;
    int unsigned pos;
    r = '0;
    key = {prio, pid};
    if (action == ACT_INSERT) begin
      if (held_count >= QDEPTH) begin
        r.error_code = ERR_FULL;
      end else begin
        pos = 0;
        while (pos < held_count && held_keys[pos] <= key) pos++;
        for (int unsigned i = held_count; i > pos; i--) held_keys[i] = held_keys[i-1];
        held_keys[pos] = key;
        held_count++;
      end
    end else if (held_count == 0) begin
      r.error_code = ERR_EMPTY;
    end else begin
      r.popped_valid = 1'b1;
      {r.popped_priority, r.popped_id} = held_keys[0];
      for (int unsigned i = 0; i + 1 < held_count; i++) held_keys[i] = held_keys[i+1];
      held_count--;
    end
    if (held_count > 0) begin
      r.head_valid = 1'b1;
      {r.head_priority, r.head_id} = held_keys[0];
    end
    r.occupancy = held_count[4:0];
    return r;
  endfunction

  task automatic send_request(logic action, logic [15:0] prio, logic [7:0] pid,
                              logic typed, result_t want);
    result_t model;
    while (!no_idle && $urandom_range(99) < 35) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= action;
    s_tdata  <= {pid, prio};
    do @(posedge clk); while (!s_tready);
    model = apply_queue_op(action, prio, pid);
    pending_results.push_back(typed ? want : model);
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    m_tready <= no_idle || ($urandom_range(99) >= 35);
  end

  always @(posedge clk) begin
    result_t want;
    result_t got;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[56:0];
      if (pending_results.size() == 0) begin
        $error("result with no request pending: m_tdata 0x%0h", m_tdata);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("error_code", want.error_code, got.error_code);
        check_field("popped_valid", want.popped_valid, got.popped_valid);
        check_field("popped_priority", want.popped_priority, got.popped_priority);
        check_field("popped_id", want.popped_id, got.popped_id);
        check_field("head_valid", want.head_valid, got.head_valid);
        check_field("head_priority", want.head_priority, got.head_priority);
        check_field("head_id", want.head_id, got.head_id);
        check_field("occupancy", want.occupancy, got.occupancy);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("sorted_priority_queue_unit verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int unsigned insert_bias;
    logic        action;
    logic [15:0] prio;
    logic [7:0]  pid;
    int unsigned pick;
    insert_bias = 50;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (DIR_ROWS[n]) begin
      send_request(DIR_ROWS[n].action, DIR_ROWS[n].key_priority, DIR_ROWS[n].process_id,
                   DIR_ROWS[n].typed, DIR_ROWS[n].want);
    end
    drain_results();

    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n % 100 == 0) begin
        pick = $urandom_range(2);
        insert_bias = (pick == 0) ? 80 : (pick == 1) ? 20 : 55;
      end
      no_idle = (n >= 500 && n < 700);
      if (n == 900) drain_results();
      action = ($urandom_range(99) < insert_bias) ? ACT_INSERT : ACT_POP;
      pick = $urandom_range(99);
      if (pick < 40) begin
        prio = 16'($urandom_range(3));
        pid  = 8'($urandom_range(3));
      end else if (pick < 50) begin
        prio = $urandom_range(1) ? 16'hFFFF : 16'h0000;
        pid  = $urandom_range(1) ? 8'hFF : 8'h00;
      end else begin
        prio = 16'($urandom);
        pid  = 8'($urandom);
      end
      send_request(action, prio, pid, 1'b0, '0);
    end
    no_idle = 1'b0;
    drain_results();
    repeat (8) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("sorted_priority_queue_unit verification clean");
    end else begin
      $display("sorted_priority_queue_unit verification failed");
    end
    $finish;
  end
endmodule
